FILE: src/pngunf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngunf_pkg
// Types and codes shared by the PNG scanline unfilter unit.
// ----------------------------------------------------------------------------
package pngunf_pkg;

	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4,
		FILT_BAD   = 3'd5
	} filt_t;

	typedef enum logic {
		REG_WIDTH     = 1'b0,
		REG_HAS_ALPHA = 1'b1
	} reg_idx_t;

	localparam logic [7:0]  FILT_MAX_CODE = 8'd4;
	localparam int          WIDTH_BITS    = 13;
	localparam logic [12:0] WIDTH_RESET   = 13'd1;

	typedef struct packed {
		logic       is_filter;
		logic       first_row;
		filt_t      filter;
		logic [1:0] chan;
		logic       last;
		logic [7:0] data;
	} item_t;

endpackage

FILE: src/pngunf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngunf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pngunf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/pngunf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngunf_ctrl
// Row tracking: filter byte detection, byte column, channel and row end.
// ----------------------------------------------------------------------------
module pngunf_ctrl
	import pngunf_pkg::*;
#(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [WIDTH_BITS-1:0]             width_pixels,
	input  logic                              has_alpha,
	input  logic                              accept,
	input  logic [7:0]                        in_byte,
	input  logic                              start_image,
	output item_t                             item,
	output logic [$clog2(MAX_WIDTH*4)-1:0]    col,
	output logic                              rd_en
);

	localparam int ROW_CAP = MAX_WIDTH * 4;
	localparam int AW      = $clog2(ROW_CAP);
	localparam int RBW     = AW + 1;

	logic [AW-1:0]  col_q;
	logic [1:0]     mod3_q;
	logic           expect_q;
	logic           first_row_q;
	filt_t          row_filter_q;

	logic [31:0]    w_wide;
	logic [RBW-1:0] w_c;
	logic [RBW-1:0] row_bytes;
	logic [AW:0]    col_inc;
	logic           last;
	logic           take_filter;
	logic [1:0]     mod3_next;
	filt_t          new_filter;

	always_comb begin
		if (width_pixels == '0) begin
			w_wide = 32'd1;
		end else if (32'(width_pixels) > 32'(MAX_WIDTH)) begin
			w_wide = 32'(MAX_WIDTH);
		end else begin
			w_wide = 32'(width_pixels);
		end
	end

	assign w_c         = w_wide[RBW-1:0];
	assign row_bytes   = has_alpha ? (w_c << 2) : (w_c + (w_c << 1));
	assign col_inc     = {1'b0, col_q} + {{AW{1'b0}}, 1'b1};
	assign last        = col_inc >= row_bytes;
	assign take_filter = start_image || expect_q;
	assign mod3_next   = (mod3_q == 2'd2) ? 2'd0 : mod3_q + 2'd1;
	assign new_filter  = (in_byte <= FILT_MAX_CODE) ? filt_t'(in_byte[2:0]) : FILT_BAD;

	always_comb begin
		item.is_filter = take_filter;
		item.first_row = first_row_q;
		item.filter    = row_filter_q;
		item.chan      = has_alpha ? col_q[1:0] : mod3_q;
		item.last      = last;
		item.data      = in_byte;
	end

	assign col   = col_q;
	assign rd_en = accept && !take_filter;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			mod3_q       <= 2'd0;
			expect_q     <= 1'b1;
			first_row_q  <= 1'b1;
			row_filter_q <= FILT_NONE;
		end else if (accept) begin
			if (take_filter) begin
				row_filter_q <= new_filter;
				col_q        <= '0;
				mod3_q       <= 2'd0;
				expect_q     <= 1'b0;
				first_row_q  <= start_image || first_row_q;
			end else if (last) begin
				col_q       <= '0;
				mod3_q      <= 2'd0;
				expect_q    <= 1'b1;
				first_row_q <= 1'b0;
			end else begin
				col_q  <= col_inc[AW-1:0];
				mod3_q <= mod3_next;
			end
		end
	end

`ifndef SYNTH
	a_mod3_tracks_col: assert property (@(posedge clk) disable iff (!arst_n)
		32'(mod3_q) == 32'(col_q) % 3)
		else $error("channel counter out of step with byte column");

	a_row_end_expects_filter: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !take_filter && last |=> expect_q && col_q == '0)
		else $error("row end did not rearm filter byte");
`endif

endmodule

FILE: src/pngunf_recon.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngunf_recon
// Reconstruction stage: predictor, prior row write-back and output register.
// ----------------------------------------------------------------------------
module pngunf_recon
	import pngunf_pkg::*;
#(
	parameter int AW = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  item_t         item_in,
	input  logic [AW-1:0] col_in,
	input  logic [7:0]    rd_data,
	output logic          in_ready,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [7:0]    wr_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          end_of_row,
	output logic          bad_filter
);

	function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		logic signed [10:0] da, db, dc;
		logic        [10:0] pa, pb, pc;
		da = $signed({3'b000, b}) - $signed({3'b000, c});
		db = $signed({3'b000, a}) - $signed({3'b000, c});
		dc = da + db;
		pa = (da < 0) ? 11'(-da) : 11'(da);
		pb = (db < 0) ? 11'(-db) : 11'(db);
		pc = (dc < 0) ? 11'(-dc) : 11'(dc);
		if (pa <= pb && pa <= pc) begin
			return a;
		end else if (pb <= pc) begin
			return b;
		end else begin
			return c;
		end
	endfunction

	logic          s1_v_q;
	item_t         item_s1;
	logic [AW-1:0] col_s1;
	logic          out_v_q;
	logic [7:0]    out_byte_q;
	logic          end_of_row_q;
	logic          bad_filter_q;
	logic [7:0]    left_q  [4];
	logic [7:0]    upper_q [4];

	logic          commit;
	logic [7:0]    a, b, c, pred, res;
	logic [8:0]    sum_ab;

	assign commit   = s1_v_q && (item_s1.is_filter || !out_v_q || out_ready);
	assign in_ready = !s1_v_q || commit;

	assign a      = left_q[item_s1.chan];
	assign c      = upper_q[item_s1.chan];
	assign b      = item_s1.first_row ? 8'd0 : rd_data;
	assign sum_ab = {1'b0, a} + {1'b0, b};

	always_comb begin
		case (item_s1.filter)
			FILT_SUB:   pred = a;
			FILT_UP:    pred = b;
			FILT_AVG:   pred = sum_ab[8:1];
			FILT_PAETH: pred = paeth(a, b, c);
			default:    pred = 8'd0;
		endcase
	end

	assign res     = item_s1.data + pred;
	assign wr_en   = commit && !item_s1.is_filter;
	assign wr_addr = col_s1;
	assign wr_data = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			s1_v_q  <= accept || (s1_v_q && !commit);
			out_v_q <= wr_en || (out_v_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
			col_s1  <= col_in;
		end
		if (wr_en) begin
			out_byte_q   <= res;
			end_of_row_q <= item_s1.last;
			bad_filter_q <= item_s1.filter == FILT_BAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				left_q[i]  <= 8'd0;
				upper_q[i] <= 8'd0;
			end
		end else if (commit) begin
			if (item_s1.is_filter) begin
				for (int i = 0; i < 4; i++) begin
					left_q[i]  <= 8'd0;
					upper_q[i] <= 8'd0;
				end
			end else begin
				left_q[item_s1.chan]  <= res;
				upper_q[item_s1.chan] <= b;
			end
		end
	end

	assign out_valid  = out_v_q;
	assign out_byte   = out_byte_q;
	assign end_of_row = end_of_row_q;
	assign bad_filter = bad_filter_q;

`ifndef SYNTH
	a_out_from_sample: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(s1_v_q && !item_s1.is_filter))
		else $error("output loaded without a sample transaction");
`endif

endmodule

FILE: src/png_scanline_unfilter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_scanline_unfilter_unit
// PNG scanline unfilter for 8-bit RGB and RGBA, one stream byte per transaction.
//
// channel  direction  handshake                    payload
// in       sink       in_valid / in_ready          in_byte, start_image
// out      source     out_valid / out_ready        out_byte, end_of_row, bad_filter
// cfg      APB slave  psel, penable, pwrite, pready paddr, pwdata, prdata
//
// one byte per cycle sustained while the output is not stalled; each sample result is registered
// first with the prior row RAM read in the stage register, then in the output register
// filter bytes give no result and leave the stage without waiting on the output
// a stalled output holds the stage; input is still taken while the stage drains
// reset clears row tracking, config and valid flags; prior row RAM holds no reset state
// ----------------------------------------------------------------------------
module png_scanline_unfilter_unit
	import pngunf_pkg::*;
#(
	parameter int MAX_WIDTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        start_image,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        end_of_row,
	output logic        bad_filter
);

	localparam int ROW_CAP = MAX_WIDTH * 4;
	localparam int AW      = $clog2(ROW_CAP);

	logic [WIDTH_BITS-1:0] width_q;
	logic                  alpha_q;
	reg_idx_t              reg_idx;
	logic                  cfg_wr;
	logic                  accept;
	item_t                 item;
	logic [AW-1:0]         rd_addr;
	logic                  rd_en;
	logic [7:0]            rd_data;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [7:0]            wr_data;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			alpha_q <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_WIDTH:     width_q <= pwdata[WIDTH_BITS-1:0];
				REG_HAS_ALPHA: alpha_q <= pwdata[0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WIDTH:     prdata = {{(32-WIDTH_BITS){1'b0}}, width_q};
			REG_HAS_ALPHA: prdata = {31'd0, alpha_q};
			default:       prdata = 32'd0;
		endcase
	end

	assign accept = in_valid && in_ready;

	pngunf_ctrl #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.width_pixels (width_q),
		.has_alpha    (alpha_q),
		.accept       (accept),
		.in_byte      (in_byte),
		.start_image  (start_image),
		.item         (item),
		.col          (rd_addr),
		.rd_en        (rd_en)
	);

	pngunf_ram #(
		.WIDTH(8),
		.DEPTH(ROW_CAP)
	) u_prior_row (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	pngunf_recon #(
		.AW(AW)
	) u_recon (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item_in    (item),
		.col_in     (rd_addr),
		.rd_data    (rd_data),
		.in_ready   (in_ready),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.end_of_row (end_of_row),
		.bad_filter (bad_filter)
	);

`ifndef SYNTH
	a_no_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && rd_en |-> wr_addr != rd_addr)
		else $error("prior row read and write hit the same entry");
`endif

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PNG scanline unfilter unit.
//
// A short table of directed bytes covers reset values, every filter type, a
// bad filter code and a start mark in the middle of a row. Random streams
// follow under several width and pixel format settings, from the narrowest
// row up to the clamped maximum. Each accepted byte is run through an
// unfilter model kept here, and every output transaction is compared with
// the oldest expected sample. Channels idle at random save in a steady phase.
// ----------------------------------------------------------------------------
module testbench;
	import pngunf_pkg::*;

	localparam int MAX_W    = 4096;
	localparam int LINE_CAP = MAX_W * 4;
	localparam int LIMIT    = 400000;
	localparam int N_DIR    = 26;

	typedef struct packed {
		logic [7:0] px;
		logic       eor;
		logic       bad;
	} recon_t;

	typedef struct packed {
		logic       s;
		logic [7:0] b;
		logic       typed;
		logic [7:0] px;
		logic       eor;
		logic       bad;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  in_byte;
	logic        start_image;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_byte;
	logic        end_of_row;
	logic        bad_filter;

	// unfilter model state
	logic [7:0]  prev_line [LINE_CAP];
	logic [7:0]  left_px [4];
	logic [7:0]  upleft_px [4];
	filt_t       cur_filter;
	int unsigned col_idx;
	bit          first_line;
	bit          want_filter;
	logic [12:0] cfg_width;
	logic        cfg_alpha;

	recon_t      recon_q [$];
	bit          cur_typed;
	recon_t      typed_val;
	int          idle_pct;
	int          mismatches;
	int          cycles;
	dir_row_t    dir_tab [N_DIR];

	png_scanline_unfilter_unit #(
		.MAX_WIDTH(MAX_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.start_image(start_image),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.end_of_row(end_of_row),
		.bad_filter(bad_filter)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		int est;
		int pa;
		int pb;
		int pc;
		est = int'(a) + int'(b) - int'(c);
		pa = est - int'(a);
		pb = est - int'(b);
		pc = est - int'(c);
		if (pa < 0) pa = -pa;
		if (pb < 0) pb = -pb;
		if (pc < 0) pc = -pc;
		if (pa <= pb && pa <= pc) return a;
		if (pb <= pc) return b;
		return c;
	endfunction

	function void unfilter_byte(input logic st, input logic [7:0] x, output bit got,
			output recon_t r);
		int unsigned bpp;
		int unsigned wdt;
		int unsigned row_len;
		int unsigned col;
		int unsigned ch;
		logic [7:0]  a;
		logic [7:0]  b;
		logic [7:0]  c;
		logic [7:0]  p;
		got = 0;
		r = '0;
		bpp = cfg_alpha ? 4 : 3;
		wdt = cfg_width;
		if (wdt < 1) wdt = 1;
		if (wdt > MAX_W) wdt = MAX_W;
		row_len = wdt * bpp;
		if (st) begin
			first_line = 1;
			want_filter = 1;
			col_idx = 0;
		end
		if (want_filter) begin
			cur_filter = (x <= FILT_MAX_CODE) ? filt_t'(x[2:0]) : FILT_BAD;
			for (int i = 0; i < 4; i++) begin
				left_px[i] = '0;
				upleft_px[i] = '0;
			end
			col_idx = 0;
			want_filter = 0;
			return;
		end
		col = (col_idx >= LINE_CAP) ? LINE_CAP - 1 : col_idx;
		ch = col % bpp;
		a = left_px[ch];
		b = first_line ? 8'h00 : prev_line[col];
		c = upleft_px[ch];
		case (cur_filter)
			FILT_SUB:   p = a;
			FILT_UP:    p = b;
			FILT_AVG:   p = 8'((9'(a) + 9'(b)) >> 1);
			FILT_PAETH: p = paeth_pick(a, b, c);
			default:    p = 8'h00;
		endcase
		r.px = x + p;
		upleft_px[ch] = b;
		left_px[ch] = r.px;
		prev_line[col] = r.px;
		r.eor = (col + 1 >= row_len);
		if (r.eor) begin
			col_idx = 0;
			want_filter = 1;
			first_line = 0;
		end else begin
			col_idx = col + 1;
		end
		r.bad = (cur_filter == FILT_BAD);
		got = 1;
	endfunction

	// input acceptance, prediction and output checking at the same clock edge
	always @(posedge clk) begin : mon
		bit     got;
		recon_t r;
		recon_t want;
		cycles++;
		if (cycles > LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
		if (arst_n && in_valid && in_ready) begin
			unfilter_byte(start_image, in_byte, got, r);
			if (got) begin
				if (cur_typed) r = typed_val;
				recon_q = {recon_q, r};
			end
		end
		if (arst_n && out_valid && out_ready) begin
			if (recon_q.size() == 0) begin
				$error("out_byte: no sample expected, got %02h", out_byte);
				mismatches++;
			end else begin
				want = recon_q.pop_front();
				if (out_byte !== want.px) begin
					$error("out_byte: expected %02h, got %02h", want.px, out_byte);
					mismatches++;
				end
				if (end_of_row !== want.eor) begin
					$error("end_of_row: expected %0d, got %0d", want.eor, end_of_row);
					mismatches++;
				end
				if (bad_filter !== want.bad) begin
					$error("bad_filter: expected %0d, got %0d", want.bad, bad_filter);
					mismatches++;
				end
			end
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= idle_pct);
	end

	task send_byte(input logic s, input logic [7:0] b, input bit typed, input recon_t r);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		cur_typed = typed;
		typed_val = r;
		in_valid <= 1'b1;
		start_image <= s;
		in_byte <= b;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task apb_write(input reg_idx_t idx, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_WIDTH) cfg_width = v[12:0];
		else cfg_alpha = v[0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// let the pipeline empty before touching the registers
	task drain();
		while (recon_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task run_phase(input logic [12:0] w, input logic alpha, input int n, input bit steady,
			input bit restarts);
		logic       s;
		logic [7:0] b;
		drain();
		apb_write(REG_WIDTH, 32'(w));
		apb_write(REG_HAS_ALPHA, 32'(alpha));
		idle_pct = steady ? 0 : 22;
		for (int k = 0; k < n; k++) begin
			s = (k == 0) || (restarts && ($urandom_range(0, 149) == 0 ||
				(want_filter && $urandom_range(0, 19) == 0)));
			if (s || want_filter) begin
				if ($urandom_range(0, 9) == 0)
					b = 8'($urandom_range(int'(FILT_MAX_CODE) + 1, 255));
				else
					b = 8'($urandom_range(0, int'(FILT_MAX_CODE)));
			end else begin
				case ($urandom_range(0, 7))
					0: b = 8'h00;
					1: b = 8'hFF;
					default: b = 8'($urandom);
				endcase
			end
			send_byte(s, b, 1'b0, '0);
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		in_byte = '0;
		start_image = 1'b0;
		out_ready = 1'b0;
		idle_pct = 22;
		mismatches = 0;
		cycles = 0;
		cur_typed = 0;
		typed_val = '0;
		foreach (prev_line[i]) prev_line[i] = '0;
		for (int i = 0; i < 4; i++) begin
			left_px[i] = '0;
			upleft_px[i] = '0;
		end
		cur_filter = FILT_NONE;
		col_idx = 0;
		first_line = 1;
		want_filter = 1;
		cfg_width = WIDTH_RESET;
		cfg_alpha = 1'b0;

		// reset width is one rgb pixel, so every row is three samples
		dir_tab = '{
			'{1'b1, 8'(FILT_NONE),  1'b0, 8'h00, 1'b0, 1'b0},
			'{1'b0, 8'h00,          1'b1, 8'h00, 1'b0, 1'b0},
			'{1'b0, 8'hFF,          1'b1, 8'hFF, 1'b0, 1'b0},
			'{1'b0, 8'h80,          1'b1, 8'h80, 1'b1, 1'b0},
			'{1'b0, 8'(FILT_SUB),   1'b0, 8'h00, 1'b0, 1'b0},
			'{1'b0, 8'hFF,          1'b0, 8'h00, 1'b0, 1'b0},
			'{1'b0, 8'h01,          1'b0, 8'h00, 1'b0, 1'b0},
			'{1'b0, 8'h7F,          1'b0, 8'h00, 1'b0, 1'b0},
			'{1'b0, 8'(FILT_UP),    1'b0, 8'h00, 1'b0, 1'b0},
			'{1'b0, 8'h01,          1'b0, 8'h00, 1'b0, 1'b0},
			'{1'b0, 8'h02,          1'b0, 8'h00, 1'b0, 1'b0},
			'{1'b0, 8'h03,          1'b0, 8'h00, 1'b0, 1'b0},
			'{1'b0, 8'(FILT_AVG),   1'b0, 8'h00, 1'b0, 1'b0},
			'{1'b0, 8'hFF,          1'b0, 8'h00, 1'b0, 1'b0},
			'{1'b0, 8'hFF,          1'b0, 8'h00, 1'b0, 1'b0},
			'{1'b0, 8'hFF,          1'b0, 8'h00, 1'b0, 1'b0},
			'{1'b0, 8'(FILT_PAETH), 1'b0, 8'h00, 1'b0, 1'b0},
			'{1'b0, 8'h10,          1'b0, 8'h00, 1'b0, 1'b0},
			'{1'b0, 8'hF0,          1'b0, 8'h00, 1'b0, 1'b0},
			'{1'b0, 8'h80,          1'b0, 8'h00, 1'b0, 1'b0},
			'{1'b0, 8'(FILT_UP),    1'b0, 8'h00, 1'b0, 1'b0},
			'{1'b0, 8'h11,          1'b0, 8'h00, 1'b0, 1'b0},
			// start mark mid-row with an unknown filter code
			'{1'b1, 8'hFF,          1'b0, 8'h00, 1'b0, 1'b0},
			'{1'b0, 8'h12,          1'b1, 8'h12, 1'b0, 1'b1},
			'{1'b0, 8'h34,          1'b1, 8'h34, 1'b0, 1'b1},
			'{1'b0, 8'h56,          1'b1, 8'h56, 1'b1, 1'b1}
		};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			send_byte(dir_tab[i].s, dir_tab[i].b, dir_tab[i].typed,
				'{dir_tab[i].px, dir_tab[i].eor, dir_tab[i].bad});
		end
		in_valid <= 1'b0;

		run_phase(13'd2, 1'b1, 250, 0, 1);
		run_phase(13'd0, 1'b0, 150, 0, 1);
		run_phase(13'd5, 1'b0, 300, 1, 1);
		run_phase(13'd3, 1'b1, 250, 0, 1);
		run_phase(13'd17, 1'b1, 250, 0, 1);
		run_phase(13'd1, 1'b1, 150, 0, 1);
		// widest rows: clamped and maximum width, start of a row only
		run_phase(13'd8191, 1'b1, 100, 0, 0);
		run_phase(13'd4096, 1'b0, 100, 0, 0);

		while (recon_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && recon_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
